FILE: rtl/hsvrgb_pkg.sv
package hsvrgb_pkg;

    localparam int HUE_W  = 13;
    localparam int CHAN_W = 8;
    localparam int SV_W   = 2 * CHAN_W;   // s*v
    localparam int D_W    = 10;           // |(hue mod 1920) - 960|, 0..960
    localparam int P_W    = 26;           // s*v*d, up to 62424000

    localparam logic [HUE_W-1:0] HUE_TURN   = 13'd5760;
    localparam logic [HUE_W-1:0] HUE_B1     = 13'd960;
    localparam logic [HUE_W-1:0] HUE_B2     = 13'd1920;
    localparam logic [HUE_W-1:0] HUE_B3     = 13'd2880;
    localparam logic [HUE_W-1:0] HUE_B4     = 13'd3840;
    localparam logic [HUE_W-1:0] HUE_B5     = 13'd4800;

    // ceil(s*v*d / 244800) through a reciprocal of 2^32 / 244800, rounded down
    localparam logic [P_W-1:0]  X_DENOM     = 26'd244800;
    localparam logic [P_W-1:0]  X_BIAS      = 26'd244799;
    localparam logic [14:0]     X_RECIP     = 15'd17544;
    localparam int              X_SHIFT     = 32;

    // ceil(s*v / 255) = floor((s*v + 255) * 65793 / 2^24), exact over 16 bits
    localparam logic [16:0]     Z_BIAS      = 17'd255;
    localparam logic [16:0]     Z_RECIP     = 17'd65793;
    localparam int              Z_SHIFT     = 24;

    typedef enum logic [2:0] {
        SECTOR_RED_YEL   = 3'd0,
        SECTOR_YEL_GRN   = 3'd1,
        SECTOR_GRN_CYN   = 3'd2,
        SECTOR_CYN_BLU   = 3'd3,
        SECTOR_BLU_MAG   = 3'd4,
        SECTOR_MAG_RED   = 3'd5
    } sector_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] brightness;
    } hsv_pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_pixel_t;

endpackage

FILE: rtl/hsv_to_rgb_converter_unit.sv
// Channel | Dir | Handshake              | Payload
// --------+-----+------------------------+-------------------------------------
// hsv     | in  | hsv_valid / hsv_stall  | hsv_pixel_t: hue, saturation, brightness
// rgb     | out | rgb_valid / rgb_stall  | rgb_pixel_t: red, green, blue
//
// Six register stages, the last one being the output register: rgb_valid rises
// once an accepted hsv transaction has passed through all six. A new pixel may
// enter every cycle unless rgb_stall backs up; throughput is one pixel per clock.
// The six stages are set by the multiplier chain: s*v, the 1/255 reciprocal,
// s*v*d, the 1/244800 reciprocal, the quotient back-multiply and the final
// correct-and-route step.
// Reset (rst_n low, asynchronous) clears all stage valid bits; data is not reset.
// Each stage holds while it is full and the stage after it cannot take it;
// empty stages keep filling, so bubbles collapse under rgb_stall.
module hsv_to_rgb_converter_unit
    import hsvrgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       hsv_valid,
    output logic       hsv_stall,
    input  hsv_pixel_t hsv,
    output logic       rgb_valid,
    input  logic       rgb_stall,
    output rgb_pixel_t rgb
);

    localparam int NSTAGE = 6;

    // Stage valid bits and per-stage advance
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] adv;

    always_comb
    begin
        adv[NSTAGE-1] = !valid_reg[NSTAGE-1] || !rgb_stall;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign hsv_stall = !adv[0];
    assign rgb_valid = valid_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= hsv_valid;
            end
            for (int i = 1; i < NSTAGE; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: wrap the hue into one turn, form s*v
    // ---------------------------------------------------------------
    logic [HUE_W-1:0]  h1_reg,  h1_next;
    logic [SV_W-1:0]   sv1_reg, sv1_next;
    logic [CHAN_W-1:0] v1_reg;

    always_comb
    begin
        h1_next  = (hsv.hue >= HUE_TURN) ? (hsv.hue - HUE_TURN) : hsv.hue;
        sv1_next = SV_W'(hsv.saturation) * SV_W'(hsv.brightness);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            h1_reg  <= h1_next;
            sv1_reg <= sv1_next;
            v1_reg  <= hsv.brightness;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: find the sector and distance d from its center line;
    // divide s*v by 255 (rounded up) through the reciprocal
    // ---------------------------------------------------------------
    sector_t           sec2_reg, sec2_next;
    logic [D_W-1:0]    d2_reg,   d2_next;
    logic [SV_W-1:0]   sv2_reg;
    logic [CHAN_W-1:0] v2_reg;
    logic [CHAN_W-1:0] zq2_reg,  zq2_next;
    logic [HUE_W-1:0]  center2;
    logic [HUE_W-1:0]  dist2;
    logic [31:0]       zprod2;

    always_comb
    begin
        if (h1_reg < HUE_B1)
        begin
            sec2_next = SECTOR_RED_YEL;
        end
        else if (h1_reg < HUE_B2)
        begin
            sec2_next = SECTOR_YEL_GRN;
        end
        else if (h1_reg < HUE_B3)
        begin
            sec2_next = SECTOR_GRN_CYN;
        end
        else if (h1_reg < HUE_B4)
        begin
            sec2_next = SECTOR_CYN_BLU;
        end
        else if (h1_reg < HUE_B5)
        begin
            sec2_next = SECTOR_BLU_MAG;
        end
        else
        begin
            sec2_next = SECTOR_MAG_RED;
        end

        // Each pair of sectors is symmetric about 960, 2880 or 4800
        case (sec2_next)
            SECTOR_RED_YEL, SECTOR_YEL_GRN: center2 = HUE_B1;
            SECTOR_GRN_CYN, SECTOR_CYN_BLU: center2 = HUE_B3;
            default:                        center2 = HUE_B5;
        endcase

        if (sec2_next[0])
        begin
            dist2 = h1_reg - center2;
        end
        else
        begin
            dist2 = center2 - h1_reg;
        end
        d2_next = dist2[D_W-1:0];

        // widen both operands so the product keeps all 32 bits
        zprod2   = 32'(17'(sv1_reg) + Z_BIAS) * 32'(Z_RECIP);
        zq2_next = zprod2[Z_SHIFT +: CHAN_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            sec2_reg <= sec2_next;
            d2_reg   <= d2_next;
            sv2_reg  <= sv1_reg;
            v2_reg   <= v1_reg;
            zq2_reg  <= zq2_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: s*v*d; the zero component is ready
    // ---------------------------------------------------------------
    sector_t           sec3_reg;
    logic [P_W-1:0]    p3_reg, p3_next;
    logic [CHAN_W-1:0] v3_reg;
    logic [CHAN_W-1:0] z3_reg, z3_next;

    always_comb
    begin
        p3_next = P_W'(sv2_reg) * P_W'(d2_reg);
        z3_next = v2_reg - zq2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            sec3_reg <= sec2_reg;
            p3_reg   <= p3_next;
            v3_reg   <= v2_reg;
            z3_reg   <= z3_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: bias for round-up, multiply by the 1/244800 reciprocal
    // ---------------------------------------------------------------
    sector_t           sec4_reg;
    logic [P_W-1:0]    n4_reg, n4_next;
    logic [40:0]       xprod4_reg, xprod4_next;
    logic [CHAN_W-1:0] v4_reg;
    logic [CHAN_W-1:0] z4_reg;

    always_comb
    begin
        n4_next     = p3_reg + X_BIAS;
        xprod4_next = 41'(n4_next) * 41'(X_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            sec4_reg   <= sec3_reg;
            n4_reg     <= n4_next;
            xprod4_reg <= xprod4_next;
            v4_reg     <= v3_reg;
            z4_reg     <= z3_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: estimated quotient, one short at most; multiply it back
    // ---------------------------------------------------------------
    sector_t           sec5_reg;
    logic [P_W-1:0]    n5_reg;
    logic [CHAN_W-1:0] q5_reg,  q5_next;
    logic [P_W-1:0]    qd5_reg, qd5_next;
    logic [CHAN_W-1:0] v5_reg;
    logic [CHAN_W-1:0] z5_reg;

    always_comb
    begin
        q5_next  = xprod4_reg[X_SHIFT +: CHAN_W];
        qd5_next = P_W'(q5_next) * X_DENOM;
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            sec5_reg <= sec4_reg;
            n5_reg   <= n4_reg;
            q5_reg   <= q5_next;
            qd5_reg  <= qd5_next;
            v5_reg   <= v4_reg;
            z5_reg   <= z4_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: correct the quotient, form X and route the channels
    // ---------------------------------------------------------------
    rgb_pixel_t        rgb_reg, rgb_next;
    logic [P_W-1:0]    rem6;
    logic [CHAN_W-1:0] q6;
    logic [CHAN_W-1:0] x6;

    always_comb
    begin
        rem6 = n5_reg - qd5_reg;
        q6   = (rem6 >= X_DENOM) ? (q5_reg + CHAN_W'(1)) : q5_reg;
        x6   = v5_reg - q6;

        case (sec5_reg)
            SECTOR_RED_YEL: rgb_next = '{red: v5_reg, green: x6,     blue: z5_reg};
            SECTOR_YEL_GRN: rgb_next = '{red: x6,     green: v5_reg, blue: z5_reg};
            SECTOR_GRN_CYN: rgb_next = '{red: z5_reg, green: v5_reg, blue: x6};
            SECTOR_CYN_BLU: rgb_next = '{red: z5_reg, green: x6,     blue: v5_reg};
            SECTOR_BLU_MAG: rgb_next = '{red: x6,     green: z5_reg, blue: v5_reg};
            default:        rgb_next = '{red: v5_reg, green: z5_reg, blue: x6};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb = rgb_reg;

endmodule
